// ===== hw/rtl/sgam_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sgam_pkg;

  // Sample ports on the top level, and the default number of mixed sources.
  localparam int unsigned SAMPLE_FIELDS   = 4;
  localparam int unsigned SOURCES_DEFAULT = 4;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Q2.14 gain: 14 fraction bits, unity is 1 << 14.
  localparam int unsigned Q_FRAC = 14;
  localparam logic [GAIN_W-1:0] Q_ONE = GAIN_W'(1 << Q_FRAC);

  // Product of a signed sample and an unsigned gain, and the term after the scale.
  localparam int unsigned PROD_W = SAMPLE_W + GAIN_W;
  localparam int unsigned TERM_W = PROD_W - Q_FRAC;
  localparam int unsigned ACC_W  = TERM_W + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FIRST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SECOND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_THIRD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FOURTH  = 3'd5;

  localparam logic [COUNT_W-1:0] SOURCE_COUNT_RESET = 3'd1;

  // Add one term to the running sum and clamp to the 16-bit or 32-bit signed range.
  function automatic logic signed [SAMPLE_W-1:0] sat_add(
    input logic signed [SAMPLE_W-1:0] sum,
    input logic signed [TERM_W-1:0]   term,
    input logic                       wide
  );
    logic signed [ACC_W-1:0] total;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    total = ACC_W'(sum) + ACC_W'(term);
    if (wide) begin
      hi = ACC_W'(32'sh7FFF_FFFF);
      lo = ACC_W'(-64'sd2147483648);
    end else begin
      hi = ACC_W'(32767);
      lo = ACC_W'(-32768);
    end
    if (total > hi) begin
      sat_add = hi[SAMPLE_W-1:0];
    end else if (total < lo) begin
      sat_add = lo[SAMPLE_W-1:0];
    end else begin
      sat_add = total[SAMPLE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/saturating_gain_audio_mixer_unit.sv =====
// Saturating gain audio mixer.
// Input channel: sample_a..sample_d, present_mask and frame_end move on a transfer
// (in_valid high, in_stall low). Output channel: mixed_sample and frame_end_out,
// out_valid / out_stall. One result leaves for every item taken, in order.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data); write it
// only while no item is in flight. Indexes: 0 source count, 1 wide samples,
// 2..5 gains of sources 0..3 (unsigned Q2.14, 16384 is unity).
// Pipeline: input capture, multiply, scale by 1/16384 toward zero, then one
// saturating add per source lane. mixed_sample comes from the last add stage,
// whose valid bit is out_valid. Throughput is one item per cycle while
// out_stall is low: each lane has its own multiplier and each accumulate
// stage its own adder.
// Stages hold their data under a stall; an empty stage still loads, so bubbles
// close up and items keep entering until every stage is full.
// Reset clears all valid bits and returns the registers to one source, 16-bit
// mode and unity gains.
`timescale 1ns / 1ps
`default_nettype none

module saturating_gain_audio_mixer_unit #(
  parameter int unsigned SOURCES = sgam_pkg::SOURCES_DEFAULT
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      cfg_write,
  input  wire  [sgam_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire  [sgam_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  wire                                      in_valid,
  output logic                                     in_stall,
  input  wire  signed [sgam_pkg::SAMPLE_W-1:0]     sample_a,
  input  wire  signed [sgam_pkg::SAMPLE_W-1:0]     sample_b,
  input  wire  signed [sgam_pkg::SAMPLE_W-1:0]     sample_c,
  input  wire  signed [sgam_pkg::SAMPLE_W-1:0]     sample_d,
  input  wire  [sgam_pkg::SAMPLE_FIELDS-1:0]       present_mask,
  input  wire                                      frame_end,
  output logic                                     out_valid,
  input  wire                                      out_stall,
  output logic signed [sgam_pkg::SAMPLE_W-1:0]     mixed_sample,
  output logic                                     frame_end_out
);

  localparam int unsigned LANES =
    (SOURCES < sgam_pkg::SAMPLE_FIELDS) ? SOURCES : sgam_pkg::SAMPLE_FIELDS;
  localparam int unsigned NST = 3 + LANES;

  localparam int unsigned SW = sgam_pkg::SAMPLE_W;
  localparam int unsigned PW = sgam_pkg::PROD_W;
  localparam int unsigned TW = sgam_pkg::TERM_W;
  localparam int unsigned FR = sgam_pkg::Q_FRAC;

  typedef logic signed [TW-1:0] term_t;
  typedef term_t term_row_t [LANES];

  // Configuration registers
  logic [sgam_pkg::COUNT_W-1:0] source_count;
  logic                         wide_samples;
  logic [sgam_pkg::GAIN_W-1:0]  gain [sgam_pkg::SAMPLE_FIELDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      source_count <= sgam_pkg::SOURCE_COUNT_RESET;
      wide_samples <= 1'b0;
      for (int k = 0; k < sgam_pkg::SAMPLE_FIELDS; k++) begin
        gain[k] <= sgam_pkg::Q_ONE;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        sgam_pkg::REG_SOURCE_COUNT: source_count <= cfg_data[sgam_pkg::COUNT_W-1:0];
        sgam_pkg::REG_WIDE_SAMPLES: wide_samples <= cfg_data[0];
        sgam_pkg::REG_GAIN_FIRST:   gain[0] <= cfg_data;
        sgam_pkg::REG_GAIN_SECOND:  gain[1] <= cfg_data;
        sgam_pkg::REG_GAIN_THIRD:   gain[2] <= cfg_data;
        sgam_pkg::REG_GAIN_FOURTH:  gain[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits and the load chain: a stage loads when empty or moving on.
  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = !out_stall;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage 0: capture samples, narrowed in 16-bit mode, and the lanes that count.
  logic signed [SW-1:0] in_sample [sgam_pkg::SAMPLE_FIELDS];
  logic [LANES-1:0]     in_mask;

  always_comb begin
    in_sample[0] = sample_a;
    in_sample[1] = sample_b;
    in_sample[2] = sample_c;
    in_sample[3] = sample_d;
    if (!wide_samples) begin
      for (int k = 0; k < sgam_pkg::SAMPLE_FIELDS; k++) begin
        in_sample[k] = SW'(signed'(in_sample[k][15:0]));
      end
    end
    for (int k = 0; k < LANES; k++) begin
      in_mask[k] = present_mask[k] && (source_count > sgam_pkg::COUNT_W'(k));
    end
  end

  logic signed [SW-1:0] s0_sample [LANES];
  logic [LANES-1:0]     s0_mask;
  logic                 s0_fe;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int k = 0; k < LANES; k++) begin
        s0_sample[k] <= in_sample[k];
      end
      s0_mask <= in_mask;
      s0_fe   <= frame_end;
    end
  end

  // Stage 1: one multiplier per lane.
  logic signed [PW-1:0] s1_prod [LANES];
  logic [LANES-1:0]     s1_mask;
  logic                 s1_fe;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int k = 0; k < LANES; k++) begin
        s1_prod[k] <= PW'(s0_sample[k] * signed'({1'b0, gain[k]}));
      end
      s1_mask <= s0_mask;
      s1_fe   <= s0_fe;
    end
  end

  // Stage 2: divide by 2^14 toward zero (bias negatives), zero absent lanes.
  logic signed [PW-1:0] biased [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      biased[k] = s1_prod[k] + PW'({FR{s1_prod[k][PW-1]}});
    end
  end

  term_row_t s2_term;
  logic      s2_fe;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int k = 0; k < LANES; k++) begin
        s2_term[k] <= s1_mask[k] ? biased[k][PW-1:FR] : '0;
      end
      s2_fe <= s1_fe;
    end
  end

  // Accumulate stages: stage j adds lane j and carries the later terms along.
  logic signed [SW-1:0] acc_sum  [LANES];
  logic                 acc_fe   [LANES];
  term_row_t            acc_term [LANES-1];

  logic signed [SW-1:0] src_sum  [LANES];
  logic                 src_fe   [LANES];
  term_row_t            src_term [LANES];

  always_comb begin
    src_sum[0]  = '0;
    src_fe[0]   = s2_fe;
    src_term[0] = s2_term;
    for (int j = 1; j < LANES; j++) begin
      src_sum[j]  = acc_sum[j-1];
      src_fe[j]   = acc_fe[j-1];
      src_term[j] = acc_term[j-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < LANES; j++) begin
      if (rdy[3+j]) begin
        acc_sum[j] <= sgam_pkg::sat_add(src_sum[j], src_term[j][j], wide_samples);
        acc_fe[j]  <= src_fe[j];
      end
    end
    for (int j = 0; j < LANES - 1; j++) begin
      if (rdy[3+j]) begin
        acc_term[j] <= src_term[j];
      end
    end
  end

  assign out_valid     = v[NST-1];
  assign mixed_sample  = acc_sum[LANES-1];
  assign frame_end_out = acc_fe[LANES-1];

  // Checks
  a_narrow_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !wide_samples) |->
      (mixed_sample <= 32767 && mixed_sample >= -32768))
    else $error("narrow mix outside 16-bit range");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&v) && out_stall))
    else $error("input held off with room in the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

// ===== verif/mix_scoreboard_pkg.sv =====
`timescale 1ns / 1ps

package mix_scoreboard_pkg;
  import sgam_pkg::*;

  localparam int unsigned MIX_SOURCES = SOURCES_DEFAULT;
  localparam longint Q_SCALE = 1 << Q_FRAC;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t sample_set_t [SAMPLE_FIELDS];

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed;
    logic                       frame_end;
  } mix_result_t;

  class mix_scoreboard;
    logic [COUNT_W-1:0] source_count;
    logic               wide;
    logic [GAIN_W-1:0]  gains [SAMPLE_FIELDS];
    mix_result_t        expected_mixes [$];
    int                 errors;

    function new();
      source_count = SOURCE_COUNT_RESET;
      wide = 1'b0;
      foreach (gains[k]) gains[k] = Q_ONE;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SOURCE_COUNT: source_count = val[COUNT_W-1:0];
        REG_WIDE_SAMPLES: wide = val[0];
        REG_GAIN_FIRST:   gains[0] = val[GAIN_W-1:0];
        REG_GAIN_SECOND:  gains[1] = val[GAIN_W-1:0];
        REG_GAIN_THIRD:   gains[2] = val[GAIN_W-1:0];
        REG_GAIN_FOURTH:  gains[3] = val[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // Sources in order; saturate after every add, scale truncates toward zero.
    function sample_t predict_mix(sample_set_t smp, logic [SAMPLE_FIELDS-1:0] mask);
      longint lanes, lo, hi, acc, s, term;
      lanes = source_count;
      if (lanes > MIX_SOURCES) lanes = MIX_SOURCES;
      if (lanes > SAMPLE_FIELDS) lanes = SAMPLE_FIELDS;
      lo = wide ? -64'sd2147483648 : -64'sd32768;
      hi = wide ? 64'sd2147483647 : 64'sd32767;
      acc = 0;
      for (int k = 0; k < lanes; k++) begin
        if (mask[k]) begin
          s = wide ? longint'(smp[k]) : longint'($signed(smp[k][15:0]));
          term = (s * longint'(gains[k])) / Q_SCALE;
          acc = acc + term;
          if (acc > hi) acc = hi;
          if (acc < lo) acc = lo;
        end
      end
      return sample_t'(acc);
    endfunction

    function void note_input(sample_set_t smp, logic [SAMPLE_FIELDS-1:0] mask, logic fe);
      mix_result_t want;
      want.mixed = predict_mix(smp, mask);
      want.frame_end = fe;
      expected_mixes.insert(expected_mixes.size(), want);
    endfunction

    function int pending();
      return expected_mixes.size();
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(sample_t mixed, logic fe);
      mix_result_t want;
      if (expected_mixes.size() == 0) begin
        report($sformatf("result %0d with no transfer pending", mixed));
        return;
      end
      want = expected_mixes[0];
      expected_mixes.delete(0);
      if (mixed !== want.mixed)
        report($sformatf("mixed_sample %0d, want %0d", mixed, want.mixed));
      if (fe !== want.frame_end)
        report($sformatf("frame_end_out %b, want %b", fe, want.frame_end));
    endtask
  endclass

endpackage

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import sgam_pkg::*;
  import mix_scoreboard_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 2000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 115;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  sample_t                  sample_a, sample_b, sample_c, sample_d;
  logic [SAMPLE_FIELDS-1:0] present_mask;
  logic                     frame_end;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  sample_t                  mixed_sample;
  logic                     frame_end_out;

  mix_scoreboard mix_check = new();
  logic quiet;
  int   hold_requests;
  int   holds_served = 0;
  int   hold_left = 0;
  int   stuck_cycles = 0;

  saturating_gain_audio_mixer_unit #(.SOURCES(MIX_SOURCES)) dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .sample_a, .sample_b, .sample_c, .sample_d,
    .present_mask, .frame_end,
    .out_valid, .out_stall, .mixed_sample, .frame_end_out
  );

  always #10 clk = ~clk;

  function automatic sample_t random_sample(logic wide);
    case ($urandom_range(0, 9))
      0: return wide ? 32'sh7FFF_FFFF : 32'sd32767;
      1: return wide ? 32'sh8000_0000 : -32'sd32768;
      2: return sample_t'($urandom);
      default: return wide ? sample_t'($urandom) : sample_t'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return Q_ONE;
      default: return GAIN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic write_config(input logic [COUNT_W-1:0] count, input logic wide,
                              input logic [GAIN_W-1:0] g0, g1, g2, g3);
    logic [CFG_IDX_W-1:0]  regs [6];
    logic [CFG_DATA_W-1:0] vals [6];
    regs = '{REG_SOURCE_COUNT, REG_WIDE_SAMPLES, REG_GAIN_FIRST,
             REG_GAIN_SECOND, REG_GAIN_THIRD, REG_GAIN_FOURTH};
    vals = '{CFG_DATA_W'(count), CFG_DATA_W'(wide), g0, g1, g2, g3};
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      mix_check.set_register(regs[i], vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic send_item(input sample_t a, b, c, d,
                           input logic [SAMPLE_FIELDS-1:0] mask, input logic fe);
    sample_set_t smp;
    smp = '{a, b, c, d};
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_a     <= a;
    sample_b     <= b;
    sample_c     <= c;
    sample_d     <= d;
    present_mask <= mask;
    frame_end    <= fe;
    do @(posedge clk); while (in_stall);
    mix_check.note_input(smp, mask, fe);
  endtask

  // Hold the input low and let every expected result come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (mix_check.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    logic w;
    w = mix_check.wide;
    repeat (count)
      send_item(random_sample(w), random_sample(w), random_sample(w), random_sample(w),
                SAMPLE_FIELDS'($urandom_range(0, 15)), $urandom_range(0, 7) == 0);
  endtask

  // Receiver: random stalls, long hold-off on request, result check.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 10);
    end
    if (!rst && out_valid && !out_stall)
      mix_check.check_result(mixed_sample, frame_end_out);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    sample_a      <= '0;
    sample_b      <= '0;
    sample_c      <= '0;
    sample_d      <= '0;
    present_mask  <= '0;
    frame_end     <= 1'b0;
    quiet         <= 1'b0;
    hold_requests <= 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: one source, narrow, unity gain; upper bits ignored in narrow mode.
    send_item(32'sh7FFF_FFFF, 32'sd1, 32'sd1, 32'sd1, 4'hF, 1'b1);
    send_item(32'sh0001_8000, 32'sd0, 32'sd0, 32'sd0, 4'h1, 1'b0);
    send_item(32'sd32767, 32'sd5, 32'sd5, 32'sd5, 4'hE, 1'b0);
    drain();

    // Narrow saturation, both ends, and absent sources.
    write_config(3'd4, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(32'sd32767, 32'sd32767, 32'sd32767, 32'sd32767, 4'hF, 1'b1);
    send_item(-32'sd32768, -32'sd32768, -32'sd32768, -32'sd32768, 4'hF, 1'b0);
    send_item(32'sd32767, -32'sd32768, 32'sd32767, -32'sd32768, 4'hA, 1'b1);
    send_item(32'sd32767, 32'sd32767, -32'sd32768, -32'sd32768, 4'hF, 1'b0);
    send_item(32'sd32767, 32'sd32767, 32'sd32767, 32'sd32767, 4'h0, 1'b0);
    drain();

    // No sources in the mix.
    write_config(3'd0, 1'b1, 16'd1, 16'd1, 16'd1, 16'd1);
    send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 4'hF, 1'b1);
    drain();

    // Count beyond the lanes, wide saturation in both directions.
    write_config(3'd7, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 4'hF, 1'b0);
    send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 4'hF, 1'b1);
    send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 4'hF, 1'b0);
    send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 4'hF, 1'b1);
    drain();

    // Truncation toward zero with tiny and odd gains.
    write_config(3'd5, 1'b0, 16'd1, 16'd16383, 16'd16385, 16'd0);
    send_item(-32'sd1, -32'sd32768, 32'sd32767, 32'sd5, 4'hF, 1'b0);
    send_item(32'sh8000_0000, 32'shFFFF_0001, -32'sd3, 32'sd32767, 4'hF, 1'b1);
    drain();

    // Sources past the count are left out.
    write_config(3'd2, 1'b1, 16'd0, Q_ONE, 16'hFFFF, 16'hFFFF);
    send_item(32'sh8000_0000, 32'sd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 4'hF, 1'b0);
    send_item(-32'sd1, -32'sd1, -32'sd1, -32'sd1, 4'hF, 1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_config(COUNT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   random_gain(), random_gain(), random_gain(), random_gain());
      if (p == 3) hold_requests <= hold_requests + 1;
      if (p == 5) quiet <= 1'b1;
      send_random(PHASE_ITEMS);
      drain();
      quiet <= 1'b0;
    end

    repeat (10) @(posedge clk);
    if (mix_check.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
